/* rtl/tlbw_pkg.sv */
`timescale 1ns / 1ps
package tlbw_pkg;

  localparam int TLB_ENTRIES = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int LFSR_W = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  localparam logic FUNC_XLATE = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  localparam logic KIND_ADDR = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic CFG_PAGING = 1'b0;
  localparam logic CFG_DIR_BASE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIT,
    PH_DIR,
    PH_TABLE
  } phase_t;

  typedef enum logic [2:0] {
    OUT_PASS,
    OUT_HIT,
    OUT_DIR,
    OUT_TABLE,
    OUT_FILL
  } out_sel_t;

  typedef struct packed {
    logic     load_out;
    out_sel_t out_sel;
    logic     latch_lin;
    logic     frame_rd;
    logic     start_walk;
    logic     fill;
  } cmd_t;

  typedef struct packed {
    logic paging;
    logic hit;
    logic out_free;
    logic victim_ready;
  } status_t;

endpackage

/* rtl/tlbw_ctrl.sv */
`timescale 1ns / 1ps
module tlbw_ctrl import tlbw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  input  logic    s_axis_tuser,
  output logic    s_axis_tready,
  input  status_t status,
  output cmd_t    cmd
);

  phase_t state;
  phase_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = s_axis_tvalid & s_axis_tready;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.out_sel = OUT_PASS;
    s_axis_tready = 1'b0;
    unique case (state)
      PH_IDLE: begin
        s_axis_tready = status.out_free;
        if (accept && s_axis_tuser == FUNC_XLATE) begin
          if (!status.paging) begin
            cmd.load_out = 1'b1;
            cmd.out_sel = OUT_PASS;
          end else if (status.hit) begin
            cmd.frame_rd = 1'b1;
            cmd.latch_lin = 1'b1;
            state_next = PH_HIT;
          end else begin
            cmd.load_out = 1'b1;
            cmd.out_sel = OUT_DIR;
            cmd.latch_lin = 1'b1;
            cmd.start_walk = 1'b1;
            state_next = PH_DIR;
          end
        end
      end
      PH_HIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel = OUT_HIT;
          state_next = PH_IDLE;
        end
      end
      PH_DIR: begin
        s_axis_tready = status.out_free;
        if (accept && s_axis_tuser == FUNC_DATA) begin
          cmd.load_out = 1'b1;
          cmd.out_sel = OUT_TABLE;
          state_next = PH_TABLE;
        end
      end
      PH_TABLE: begin
        s_axis_tready = status.out_free & status.victim_ready;
        if (accept && s_axis_tuser == FUNC_DATA) begin
          cmd.load_out = 1'b1;
          cmd.out_sel = OUT_FILL;
          cmd.fill = 1'b1;
          state_next = PH_IDLE;
        end
      end
      default: begin
        state_next = PH_IDLE;
      end
    endcase
  end

endmodule

/* rtl/tlbw_datapath.sv */
`timescale 1ns / 1ps
module tlbw_datapath import tlbw_pkg::*; #(
  parameter int ENTRIES = TLB_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tuser,
  input  cmd_t        cmd,
  output status_t     status
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = LFSR_W + 32;
  localparam logic [63:0] RECIP_WIDE = (64'd1 << 32) / 64'(ENTRIES);
  localparam logic [31:0] RECIP = RECIP_WIDE[31:0];

  logic              paging;
  logic [19:0]       dir_base;
  logic [19:0]       tag_q [ENTRIES];
  logic [19:0]       frame_mem [ENTRIES];
  logic [19:0]       frame_q;
  logic [CW-1:0]     cnt;
  logic [31:0]       pend_lin;
  logic [IW-1:0]     victim;
  logic [LFSR_W-1:0] lfsr;
  logic              mod_busy;
  logic [PW-1:0]     mod_prod;
  logic [LFSR_W-1:0] mod_q;
  logic [LFSR_W-1:0] mod_sh;
  logic [LFSR_W-1:0] mod_rem;
  logic [LFSR_W-1:0] mod_fix;
  logic [31:0]       in_lin;
  logic [31:0]       in_data;
  logic              full;
  logic              hit_any;
  logic [IW-1:0]     hit_idx;
  logic              out_free;
  logic              kind_next;
  logic [31:0]       addr_next;

  assign in_lin = s_axis_tdata[31:0];
  assign in_data = s_axis_tdata[63:32];
  assign full = (cnt == CW'(ENTRIES));
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      paging <= 1'b0;
      dir_base <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAGING:   paging <= cfg_data[0];
        CFG_DIR_BASE: dir_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if ((CW'(i) < cnt) && (tag_q[i] == in_lin[31:12])) begin
        hit_any = 1'b1;
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      tag_q[victim] <= pend_lin[31:12];
      frame_mem[victim] <= in_data[31:12];
    end
    if (cmd.frame_rd) begin
      frame_q <= frame_mem[hit_idx];
    end
    if (cmd.latch_lin) begin
      pend_lin <= in_lin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.fill && !full) begin
      cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_SEED;
    end else if (cmd.start_walk && full) begin
      lfsr <= {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};
    end
  end

  // victim slot: next free entry until full, else LFSR remainder by the
  // entry count via a reciprocal multiply, then one correction step
  assign mod_prod = PW'(lfsr) * PW'(RECIP);
  assign mod_rem = mod_sh - mod_q * LFSR_W'(ENTRIES);
  assign mod_fix = (mod_rem >= LFSR_W'(ENTRIES)) ? mod_rem - LFSR_W'(ENTRIES) : mod_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_busy <= 1'b0;
    end else if (cmd.start_walk && full) begin
      mod_busy <= 1'b1;
    end else begin
      mod_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      mod_sh <= lfsr;
      mod_q <= mod_prod[PW-1:32];
      if (!full) begin
        victim <= cnt[IW-1:0];
      end
    end else if (mod_busy) begin
      victim <= mod_fix[IW-1:0];
    end
  end

  always_comb begin
    case (cmd.out_sel)
      OUT_PASS: begin
        kind_next = KIND_ADDR;
        addr_next = in_lin;
      end
      OUT_HIT: begin
        kind_next = KIND_ADDR;
        addr_next = {frame_q, pend_lin[11:0]};
      end
      OUT_DIR: begin
        kind_next = KIND_READ;
        addr_next = {dir_base, 12'h000} + {20'h00000, in_lin[31:22], 2'b00};
      end
      OUT_TABLE: begin
        kind_next = KIND_READ;
        addr_next = {in_data[31:12], 12'h000} + {20'h00000, pend_lin[21:12], 2'b00};
      end
      OUT_FILL: begin
        kind_next = KIND_ADDR;
        addr_next = {in_data[31:12], pend_lin[11:0]};
      end
      default: begin
        kind_next = KIND_ADDR;
        addr_next = in_lin;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_axis_tuser <= kind_next;
      m_axis_tdata <= addr_next;
    end
  end

  assign status.paging = paging;
  assign status.hit = hit_any;
  assign status.out_free = out_free;
  assign status.victim_ready = !mod_busy;

  a_fill_victim_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |-> !mod_busy)
    else $error("fill while victim slot still being computed");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(ENTRIES))
    else $error("fill count beyond entry count");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("output register overwritten before taken");

  a_busy_only_full: assert property (@(posedge clk) disable iff (rst)
    $rose(mod_busy) |-> full)
    else $error("random victim chosen with free entries left");

endmodule

/* rtl/tlb_with_two_level_page_walk_core.sv */
`timescale 1ns / 1ps
// Pass-through: result in the output register in the cycle after the beat; beats flow on
// while the output is taken. A TLB hit goes through the registered frame memory read and
// blocks new beats until loaded; a miss puts the directory read out in the cycle after
// the beat. A walk waits on the two memory beats; with all entries valid the victim
// remainder is ready before the table beat. Reset (synchronous): TLB empty, paging off.
module tlb_with_two_level_page_walk_core import tlbw_pkg::*; #(
  parameter int ENTRIES = TLB_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // linear_addr, read_data
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // address
  output logic        m_axis_tuser   // kind
);

  cmd_t    cmd;
  status_t status;

  tlbw_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  tlbw_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

/* sim/tb_tlb_with_two_level_page_walk_core.sv */
`timescale 1ns / 1ps
module tb_tlb_with_two_level_page_walk_core;
  import tlbw_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
  } xlat_res_t;

  class xlate_scoreboard;
    xlat_res_t   due_q[$];
    logic        paging;
    logic [19:0] dir_base;
    logic [19:0] tag[TLB_ENTRIES];
    logic [19:0] frame[TLB_ENTRIES];
    bit          valid[TLB_ENTRIES];
    phase_t      phase;
    logic [31:0] pend_lin;
    int          victim;
    logic [15:0] lfsr;
    int          errors;

    function new();
      paging = 1'b0;
      dir_base = '0;
      foreach (valid[i]) begin
        valid[i] = 1'b0;
        tag[i] = '0;
        frame[i] = '0;
      end
      phase = PH_IDLE;
      pend_lin = '0;
      victim = 0;
      lfsr = LFSR_SEED;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [19:0] value);
      if (idx == CFG_PAGING) paging = value[0];
      else dir_base = value;
    endfunction

    function void queue_result(logic kind, logic [31:0] addr);
      xlat_res_t r;
      r.kind = kind;
      r.addr = addr;
      due_q.push_back(r);
    endfunction

    function bit walking();
      return phase == PH_DIR || phase == PH_TABLE;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // returns 1 when the beat gives rise to a result
    function bit note(logic func, logic [31:0] lin, logic [31:0] rdata);
      int i;
      if (func == FUNC_XLATE) begin
        if (walking()) return 1'b0;
        if (!paging) begin
          queue_result(KIND_ADDR, lin);
          return 1'b1;
        end
        i = 0;
        while (i < TLB_ENTRIES && valid[i]) begin
          if (tag[i] == lin[31:12]) begin
            queue_result(KIND_ADDR, {frame[i], lin[11:0]});
            return 1'b1;
          end
          i++;
        end
        if (i == TLB_ENTRIES) begin
          i = int'(lfsr) % TLB_ENTRIES;
          lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
        end
        victim = i;
        pend_lin = lin;
        phase = PH_DIR;
        queue_result(KIND_READ, {dir_base, 12'h000} + {20'h0, lin[31:22], 2'b00});
        return 1'b1;
      end
      if (phase == PH_DIR) begin
        phase = PH_TABLE;
        queue_result(KIND_READ, {rdata[31:12], 12'h000} + {20'h0, pend_lin[21:12], 2'b00});
        return 1'b1;
      end
      if (phase == PH_TABLE) begin
        tag[victim] = pend_lin[31:12];
        frame[victim] = rdata[31:12];
        valid[victim] = 1'b1;
        phase = PH_IDLE;
        queue_result(KIND_ADDR, {rdata[31:12], pend_lin[11:0]});
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check(logic kind, logic [31:0] addr);
      xlat_res_t want;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: kind %0d address %08h", kind, addr);
        return;
      end
      want = due_q.pop_front();
      if (want.kind !== kind || want.addr !== addr) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected kind %0d address %08h, got kind %0d address %08h",
                   want.kind, want.addr, kind, addr);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [19:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;  // linear_addr, read_data
  logic        s_axis_tuser;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;  // address
  logic        m_axis_tuser;  // kind

  xlate_scoreboard xlat_sb;
  bit              quiet;
  int              stall_left;
  int              idle_cycles;
  logic [19:0]     page_pool[96];

  tlb_with_two_level_page_walk_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
      xlat_sb.check(m_axis_tuser, m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [19:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    xlat_sb.set_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_beat(logic func, logic [31:0] lin, logic [31:0] rdata, output bit produced);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rdata, lin};
    s_axis_tuser <= func;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    produced = xlat_sb.note(func, lin, rdata);
  endtask

  task automatic send_plain(logic func, logic [31:0] lin, logic [31:0] rdata);
    bit produced;
    send_beat(func, lin, rdata, produced);
  endtask

  // hold off until every expected beat is back and the block has settled
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (xlat_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int count);
    int          done;
    int          pick;
    bit          produced;
    logic        func;
    logic [31:0] lin;
    logic [31:0] rdata;
    done = 0;
    while (done < count || xlat_sb.walking()) begin
      pick = $urandom_range(0, 99);
      lin = $urandom();
      rdata = $urandom();
      if (xlat_sb.walking()) begin
        func = (pick < 92) ? FUNC_DATA : FUNC_XLATE;
        if (func == FUNC_XLATE)
          lin = {page_pool[$urandom_range(0, 95)], lin[11:0]};
      end else if (pick < 90) begin
        func = FUNC_XLATE;
        if (pick < 85) lin = {page_pool[$urandom_range(0, 95)], lin[11:0]};
      end else begin
        func = FUNC_DATA;
      end
      send_beat(func, lin, rdata, produced);
      if (produced) done++;
    end
  endtask

  initial begin
    xlat_sb = new();
    quiet = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    foreach (page_pool[i]) page_pool[i] = 20'($urandom());
    page_pool[0] = 20'h00000;
    page_pool[1] = 20'hFFFFF;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_PAGING;
    cfg_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= FUNC_XLATE;
    m_axis_tready <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_PAGING, 20'h0);
    write_reg(CFG_DIR_BASE, 20'h0);
    send_plain(FUNC_XLATE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_plain(FUNC_XLATE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_plain(FUNC_XLATE, 32'h1234_5678, 32'h0);
    send_plain(FUNC_DATA, 32'h0, 32'hFFFF_FFFF);
    drain();

    write_reg(CFG_PAGING, 20'h1);
    write_reg(CFG_DIR_BASE, 20'hFFFFF);
    send_plain(FUNC_XLATE, 32'hFFFF_FFFF, 32'h0);
    send_plain(FUNC_XLATE, 32'h0000_0000, 32'h0);
    send_plain(FUNC_DATA, 32'h0, 32'hFFFF_FFFF);
    send_plain(FUNC_DATA, 32'hFFFF_FFFF, 32'h0000_0000);
    send_plain(FUNC_XLATE, 32'hFFFF_F000, 32'h0);
    send_plain(FUNC_XLATE, 32'h0000_0000, 32'h0);
    send_plain(FUNC_DATA, 32'h0, 32'h0000_0ABC);
    send_plain(FUNC_DATA, 32'h0, 32'hFFFF_FFFF);
    send_plain(FUNC_XLATE, 32'h0000_0FFF, 32'h0);
    send_plain(FUNC_XLATE, 32'h8000_0000, 32'h0);
    send_plain(FUNC_DATA, 32'h0, 32'h8000_0FFF);
    send_plain(FUNC_DATA, 32'h0, 32'h7FFF_F800);
    send_plain(FUNC_DATA, 32'h0, 32'h1234_5678);
    drain();

    write_reg(CFG_DIR_BASE, 20'($urandom()));
    run_random(300);
    drain();

    write_reg(CFG_PAGING, 20'h0);
    run_random(100);
    drain();

    write_reg(CFG_PAGING, 20'h1);
    write_reg(CFG_DIR_BASE, 20'h00000);
    run_random(300);
    drain();

    write_reg(CFG_DIR_BASE, 20'hFFFFF);
    run_random(150);
    quiet = 1'b1;
    run_random(150);
    drain();

    if (xlat_sb.errors == 0 && xlat_sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tlbw_pkg.sv
rtl/tlbw_ctrl.sv
rtl/tlbw_datapath.sv
rtl/tlb_with_two_level_page_walk_core.sv
sim/tb_tlb_with_two_level_page_walk_core.sv
